[rtl/van_pkg.sv]
// Package for the variation axis normaliser: constants, codes, beat types and the sequencer
// state type. No dependencies; van_div, the core and the testbench import it.
`default_nettype none
package van_pkg;
	localparam int MaxPairs = 8;
	localparam int IdxW = 3;
	localparam int CntW = 4;
	localparam int DivW = 48;

	localparam logic [1:0] CFG_MIN = 2'd0;
	localparam logic [1:0] CFG_DEF = 2'd1;
	localparam logic [1:0] CFG_MAX = 2'd2;
	localparam logic [1:0] CFG_CNT = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ORDER = 2'd1;
	localparam logic [1:0] ST_EQUAL = 2'd2;

	typedef struct packed {
		logic mode;
		logic [31:0] user_value;
		logic [IdxW-1:0] pair_index;
		logic [15:0] pair_source;
		logic [15:0] pair_target;
	} coord_req_t;

	typedef struct packed {
		logic [15:0] mapped_coordinate;
		logic [1:0] status;
	} coord_res_t;

	typedef enum logic [3:0] {
		S_IDLE, S_NORM, S_NDIV, S_NFIN, S_SRCH, S_MUL, S_IDIV, S_IFIN, S_OUT
	} state_t;
endpackage
`default_nettype wire

[rtl/van_if.sv]
// Valid/ready channel interface carrying one beat of payload.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface van_if #(parameter type payload_t = logic) (input wire logic clk);
	logic valid;
	logic ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/van_div.sv]
// Restoring serial divider, one quotient bit per cycle, for unsigned operands.
// Depends on van_pkg.
`default_nettype none
module van_div
	import van_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [DivW-1:0] num,
	input wire logic [DivW-1:0] den,
	output logic done,
	output logic [DivW-1:0] quo,
	output logic [DivW-1:0] rem
);
	logic [DivW-1:0] d_q;
	logic [5:0] cnt_q;
	logic busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(DivW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [DivW:0] sh;
		sh = {rem, quo[DivW-1]};
		if (start) begin
			quo <= num;
			rem <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (sh >= {1'b0, d_q}) begin
				rem <= DivW'(sh - {1'b0, d_q});
				quo <= {quo[DivW-2:0], 1'b1};
			end else begin
				rem <= sh[DivW-1:0];
				quo <= {quo[DivW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

[rtl/variation_axis_normalizer_core.sv]
// Variation axis normaliser: one user coordinate in 16.16 gives one 2.14 coordinate per item.
// A coordinate takes up to two passes of a 48-step serial divider, one for the axis scaling
// and one for the segment interpolation, plus a search of one map pair per cycle. A new beat
// is taken only when the result beat has been accepted. Uses van_pkg, van_if and van_div.
`default_nettype none
module variation_axis_normalizer_core
	import van_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	van_if.sink in_ch,
	van_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	logic signed [31:0] min_q, def_q, max_q;
	logic [CntW-1:0] cnt_q;
	logic signed [15:0] src_mem [MaxPairs];
	logic signed [15:0] tgt_mem [MaxPairs];

	state_t st_q, st_d;
	logic signed [32:0] u_q;
	logic neg_q;
	logic signed [16:0] coord_q;
	logic [IdxW:0] i_q;
	logic signed [16:0] pf_q, pt_q, f_q, t_q;
	logic signed [47:0] num_q;
	logic signed [16:0] res_q;
	logic [1:0] stat_q;
	logic ovalid_q;

	logic dstart_q, ddone;
	logic [DivW-1:0] dquo, drem;
	logic [DivW-1:0] dnum_q, dden_q;
	logic [CntW-1:0] lim;
	logic signed [16:0] rd_s, rd_t;
	logic order_bad;

	van_div u_div (.clk, .arst_n, .start(dstart_q), .num(dnum_q), .den(dden_q),
		.done(ddone), .quo(dquo), .rem(drem));

	assign order_bad = (min_q > def_q) || (def_q > max_q);
	assign lim = (cnt_q > CntW'(MaxPairs)) ? CntW'(MaxPairs) : cnt_q;
	assign rd_s = 17'(src_mem[i_q[IdxW-1:0]]);
	assign rd_t = 17'(tgt_mem[i_q[IdxW-1:0]]);

	assign in_ch.ready = (st_q == S_IDLE) && !ovalid_q;
	assign out_ch.valid = ovalid_q;
	assign out_ch.payload.mapped_coordinate = res_q[15:0];
	assign out_ch.payload.status = stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			def_q <= '0;
			max_q <= '0;
			cnt_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN: min_q <= cfg_data;
				CFG_DEF: def_q <= cfg_data;
				CFG_MAX: max_q <= cfg_data;
				CFG_CNT: cnt_q <= cfg_data[CntW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: if (in_ch.valid && in_ch.ready)
				st_d = in_ch.payload.mode ? S_OUT : S_NORM;
			S_NORM: st_d = order_bad ? S_OUT : S_NDIV;
			S_NDIV: if (ddone) st_d = S_NFIN;
			S_NFIN: st_d = S_SRCH;
			S_SRCH: begin
				if (lim < CntW'(2) || i_q == (IdxW+1)'(lim)) st_d = S_OUT;
				else if (coord_q <= rd_s) begin
					if (coord_q == rd_s || i_q == '0 || rd_s <= pf_q) st_d = S_OUT;
					else st_d = S_MUL;
				end
			end
			S_MUL: st_d = S_IDIV;
			S_IDIV: if (ddone) st_d = S_IFIN;
			S_IFIN: st_d = S_OUT;
			S_OUT: st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ovalid_q <= 1'b0;
			dstart_q <= 1'b0;
		end else begin
			st_q <= st_d;
			dstart_q <= (st_q == S_NORM && !order_bad) || st_q == S_MUL;
			if (st_q == S_OUT) ovalid_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [32:0] uc;
		logic signed [33:0] rng, dif;
		logic signed [48:0] qq;
		logic signed [47:0] nm;
		if (st_q == S_IDLE && in_ch.valid && in_ch.ready) begin
			stat_q <= ST_OK;
			res_q <= '0;
			i_q <= '0;
			u_q <= 33'($signed(in_ch.payload.user_value));
			if (in_ch.payload.mode) begin
				src_mem[in_ch.payload.pair_index] <= in_ch.payload.pair_source;
				tgt_mem[in_ch.payload.pair_index] <= in_ch.payload.pair_target;
			end
		end
		unique case (st_q)
			S_NORM: begin
				uc = u_q;
				if (uc < 33'(min_q)) uc = 33'(min_q);
				if (uc > 33'(max_q)) uc = 33'(max_q);
				neg_q <= uc < 33'(def_q);
				coord_q <= '0;
				if (uc < 33'(def_q)) begin
					rng = 34'(def_q) - 34'(min_q);
					dif = 34'(def_q) - 34'(uc);
				end else begin
					rng = 34'(max_q) - 34'(def_q);
					dif = 34'(uc) - 34'(def_q);
				end
				if (rng == 34'sd0) begin
					dnum_q <= '0;
					dden_q <= DivW'(1);
				end else begin
					dnum_q <= DivW'({dif, 15'd0}) + DivW'(rng);
					dden_q <= DivW'({rng, 1'b0});
				end
				if (order_bad) stat_q <= ST_ORDER;
			end
			S_NFIN: begin
				coord_q <= neg_q ? -17'(dquo) : 17'(dquo);
				res_q <= neg_q ? -17'(dquo) : 17'(dquo);
				pf_q <= rd_s;
				pt_q <= rd_t;
			end
			S_SRCH: begin
				f_q <= rd_s;
				t_q <= rd_t;
				if (lim >= CntW'(2) && i_q != (IdxW+1)'(lim)) begin
					if (coord_q <= rd_s) begin
						if (coord_q == rd_s || i_q == '0) res_q <= rd_t;
						else if (rd_s <= pf_q) begin
							stat_q <= ST_EQUAL;
							res_q <= '0;
						end
						num_q <= 48'(34'(pt_q) * 34'(rd_s - pf_q));
					end else begin
						pf_q <= rd_s;
						pt_q <= rd_t;
						res_q <= rd_t;
						i_q <= i_q + 1'b1;
					end
				end
			end
			S_MUL: begin
				nm = num_q + 48'(34'(coord_q - pf_q) * 34'(t_q - pt_q));
				dden_q <= DivW'(f_q - pf_q);
				neg_q <= nm < 0;
				dnum_q <= (nm < 0) ? DivW'(-nm) : DivW'(nm);
			end
			S_IFIN: ;
			default: ;
		endcase
		if (st_q == S_IFIN) begin
			qq = 49'(dquo);
			if (neg_q) begin
				qq = -qq;
				if (drem != 0) qq = qq - 49'sd1;
				// Remainder in floor terms is den - rem when rem is non-zero.
				if (drem != 0) begin
					if ((DivW+1)'(dden_q - drem) * 2 > (DivW+1)'(dden_q) ||
						((DivW+1)'(dden_q - drem) * 2 == (DivW+1)'(dden_q) && qq[0]))
						qq = qq + 49'sd1;
				end
			end else begin
				if ({1'b0, drem} * 2 > (DivW+1)'(dden_q) ||
					({1'b0, drem} * 2 == (DivW+1)'(dden_q) && qq[0]))
					qq = qq + 49'sd1;
			end
			if (qq > 49'sd16384) qq = 49'sd16384;
			if (qq < -49'sd16384) qq = -49'sd16384;
			res_q <= 17'(qq);
		end
	end
endmodule
`default_nettype wire

[tb/tb_variation_axis_normalizer_core.sv]
// Self-checking testbench for variation_axis_normalizer_core: coordinate and pair-write beats
// are driven from a queue, each result beat is compared with an independent predictor.
// Depends on van_pkg, van_if and the core itself.
`timescale 1ns / 1ps
module tb_variation_axis_normalizer_core
	import van_pkg::*;
();

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	van_if #(.payload_t(coord_req_t)) in_ch (clk);
	van_if #(.payload_t(coord_res_t)) out_ch (clk);

	variation_axis_normalizer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	coord_req_t pending_reqs[$];
	coord_res_t expected_coords[$];
	int mismatches = 0;
	int idle_phase = 0;
	bit hold_sender = 0;
	bit in_taken = 0;

	longint ax_min, ax_def, ax_max;
	int unsigned pairs_used;
	longint src_tab[MaxPairs];
	longint tgt_tab[MaxPairs];

	function automatic longint scale_coord(longint u);
		longint rng;
		if (u < ax_min) u = ax_min;
		if (u > ax_max) u = ax_max;
		if (u < ax_def) begin
			rng = ax_def - ax_min;
			if (rng == 0) return 0;
			return -((2 * (ax_def - u) * 16384 + rng) / (2 * rng));
		end
		if (u > ax_def) begin
			rng = ax_max - ax_def;
			if (rng == 0) return 0;
			return (2 * (u - ax_def) * 16384 + rng) / (2 * rng);
		end
		return 0;
	endfunction

	function automatic coord_res_t predict_coord(coord_req_t r);
		coord_res_t res;
		longint c, m, pf, pt, f, t, den, num, q, rm;
		int unsigned cnt;
		res = '0;
		if (r.mode) begin
			src_tab[r.pair_index] = longint'($signed(r.pair_source));
			tgt_tab[r.pair_index] = longint'($signed(r.pair_target));
			return res;
		end
		if (ax_min > ax_def || ax_def > ax_max) begin
			res.status = ST_ORDER;
			return res;
		end
		c = scale_coord(longint'($signed(r.user_value)));
		m = c;
		cnt = (pairs_used > MaxPairs) ? MaxPairs : pairs_used;
		if (cnt >= 2) begin
			pf = src_tab[0];
			pt = tgt_tab[0];
			m = pt;
			for (int i = 0; i < cnt; i++) begin
				f = src_tab[i];
				t = tgt_tab[i];
				if (c <= f) begin
					if (c == f || i == 0) begin
						m = t;
					end else begin
						den = f - pf;
						if (den <= 0) begin
							res.status = ST_EQUAL;
							return res;
						end
						num = pt * den + (c - pf) * (t - pt);
						q = num / den;
						rm = num % den;
						if (rm < 0) begin
							q -= 1;
							rm += den;
						end
						if (2 * rm > den || (2 * rm == den && q[0])) q += 1;
						if (q > 16384) q = 16384;
						if (q < -16384) q = -16384;
						m = q;
					end
					break;
				end
				pf = f;
				pt = t;
				m = t;
			end
		end
		res.mapped_coordinate = m[15:0];
		res.status = ST_OK;
		return res;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			expected_coords.push_back(predict_coord(in_ch.payload));
			in_taken = 1;
		end
		if (out_ch.valid && out_ch.ready) begin
			if (expected_coords.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: coord %0d status %0d",
						$signed(out_ch.payload.mapped_coordinate), out_ch.payload.status);
			end else begin
				coord_res_t e;
				e = expected_coords.pop_front();
				if (e.mapped_coordinate !== out_ch.payload.mapped_coordinate ||
					e.status !== out_ch.payload.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected coord %0d status %0d, got coord %0d status %0d",
							$signed(e.mapped_coordinate), e.status,
							$signed(out_ch.payload.mapped_coordinate), out_ch.payload.status);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 0;
			out_ch.ready <= 0;
		end else begin
			out_ch.ready <= (idle_phase == 2 || idle_phase == 3) ?
				($urandom_range(99) >= ((idle_phase == 2) ? 70 : 25)) : 1'b1;
			if (!in_ch.valid || in_taken) begin
				in_taken = 0;
				if (pending_reqs.size() != 0 && !hold_sender &&
					!((idle_phase == 1 || idle_phase == 3) &&
					$urandom_range(99) < ((idle_phase == 1) ? 70 : 25))) begin
					in_ch.valid <= 1;
					in_ch.payload <= pending_reqs.pop_front();
				end else begin
					in_ch.valid <= 0;
				end
			end
		end
	end

	task automatic drain();
		while (pending_reqs.size() != 0 || expected_coords.size() != 0 || in_ch.valid)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_MIN: ax_min = longint'($signed(val));
			CFG_DEF: ax_def = longint'($signed(val));
			CFG_MAX: ax_max = longint'($signed(val));
			default: pairs_used = 32'(val[3:0]);
		endcase
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_axis(logic [31:0] mn, logic [31:0] df, logic [31:0] mx, logic [3:0] cnt);
		drain();
		write_reg(CFG_MIN, mn);
		write_reg(CFG_DEF, df);
		write_reg(CFG_MAX, mx);
		write_reg(CFG_CNT, {28'd0, cnt});
	endtask

	task automatic push_norm(logic [31:0] u);
		coord_req_t r;
		r = '0;
		r.user_value = u;
		r.pair_index = 3'($urandom);
		r.pair_source = 16'($urandom);
		r.pair_target = 16'($urandom);
		pending_reqs.push_back(r);
	endtask

	task automatic push_pair(logic [2:0] idx, logic [15:0] s, logic [15:0] t);
		coord_req_t r;
		r.mode = 1;
		r.user_value = $urandom;
		r.pair_index = idx;
		r.pair_source = s;
		r.pair_target = t;
		pending_reqs.push_back(r);
	endtask

	task automatic push_sorted_map();
		int s[MaxPairs];
		int tmp;
		for (int i = 0; i < MaxPairs; i++)
			s[i] = ($urandom_range(3) == 0) ? int'($signed(16'($urandom))) :
				int'($urandom_range(32768)) - 16384;
		for (int i = 1; i < MaxPairs; i++)
			for (int j = i; j > 0 && s[j-1] > s[j]; j--) begin
				tmp = s[j];
				s[j] = s[j-1];
				s[j-1] = tmp;
			end
		for (int i = 0; i < MaxPairs; i++)
			push_pair(3'(i), s[i][15:0], ($urandom_range(3) == 0) ? 16'($urandom) :
				16'($urandom_range(32768) - 16384));
	endtask

	initial begin
		logic [31:0] a, b, c, tmp;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		ax_min = 0;
		ax_def = 0;
		ax_max = 0;
		pairs_used = 0;
		for (int i = 0; i < MaxPairs; i++) begin
			src_tab[i] = 0;
			tgt_tab[i] = 0;
		end
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		set_axis(32'hFF9C_0000, 32'h0, 32'h0064_0000, 4'd0);
		for (int i = 0; i < MaxPairs; i++)
			push_pair(3'(i), 16'(i * 4096 - 14336), 16'(i * 3000 - 12000));
		push_norm(32'h8000_0000);
		push_norm(32'h7FFF_FFFF);
		push_norm(32'h0);
		push_norm(32'hFFCE_0000);
		push_norm(32'h0032_0000);
		set_axis(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 4'd8);
		push_norm(32'h8000_0000);
		push_norm(32'h7FFF_FFFF);
		push_norm(32'h0);
		push_norm(32'hC000_0000);
		push_norm(32'h2000_0000);
		push_pair(3, 16'h8000, 16'h7FFF);
		push_pair(4, 16'h7FFF, 16'h8000);
		push_norm(32'h1000_0000);
		push_norm(32'h7FFF_FFFF);
		set_axis(32'h0001_0000, 32'h0, 32'h0002_0000, 4'd15);
		push_norm(32'h0);
		set_axis(32'h0, 32'h0, 32'h0001_0000, 4'd1);
		push_norm(32'hFFFF_0000);
		push_norm(32'h0000_8000);
		set_axis(32'hFFFF_0000, 32'h0, 32'h0, 4'd2);
		push_norm(32'h0001_0000);
		push_norm(32'hFFFF_8000);

		hold_sender = 1;
		while (expected_coords.size() != 0 || in_ch.valid) @(posedge clk);
		hold_sender = 0;

		for (int ph = 0; ph < 12; ph++) begin
			idle_phase = ph % 4;
			a = $urandom;
			b = $urandom;
			c = $urandom;
			if ($urandom_range(1)) begin
				a = {{16{a[31]}}, a[15:0]};
				b = {{16{b[31]}}, b[15:0]};
				c = {{16{c[31]}}, c[15:0]};
			end
			if ($signed(a) > $signed(b)) begin tmp = a; a = b; b = tmp; end
			if ($signed(b) > $signed(c)) begin tmp = b; b = c; c = tmp; end
			if ($signed(a) > $signed(b)) begin tmp = a; a = b; b = tmp; end
			if (ph == 5) set_axis(c, b, a, 4'($urandom));
			else set_axis(a, b, c, (ph == 0) ? 4'd8 : 4'($urandom));
			push_sorted_map();
			for (int k = 0; k < 55; k++) begin
				case ($urandom_range(9))
					0: push_pair(3'($urandom), 16'($urandom), 16'($urandom));
					1, 2: push_norm($urandom);
					3: push_norm($signed(b) + $signed(32'($urandom_range(2000))) - 1000);
					default: push_norm($signed(a) +
						32'(longint'($urandom) % (longint'($signed(c)) - $signed(a) + 1)));
				endcase
			end
		end

		while (pending_reqs.size() != 0 || expected_coords.size() != 0 || in_ch.valid)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0) begin
			$display("[variation_axis_normalizer_core] OK");
		end else begin
			$display("[variation_axis_normalizer_core] ERROR");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (expected_coords.size() != 0 && out_ch.valid === 1'bx) begin
			mismatches++;
		end
	end

	initial begin
		#20ms;
		$display("[variation_axis_normalizer_core] ERROR");
		$finish;
	end
endmodule

[sim.f]
rtl/van_pkg.sv
rtl/van_if.sv
rtl/van_div.sv
rtl/variation_axis_normalizer_core.sv
tb/tb_variation_axis_normalizer_core.sv
